@@ design/rsd_pkg.sv @@
// rsd_pkg: shared constants, types and state encoding of the rice stream decoder
// no dependencies; used by the interfaces, rsd_code_acc and rice_stream_decoder_unit

package rsd_pkg;

  // stream geometry
  localparam int WORD_BITS   = 32;
  localparam int DATA_W      = 32;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int MAX_RESULTS = 16;
  localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

  // code fields
  localparam int K_W     = 5;
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 32;
  localparam int QUOT_W  = 32;
  localparam int REM_W   = 31;

  localparam logic [K_W-1:0]   K_RESET = K_W'(6);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_FLUSH
  } rsd_state_e;

  // control from the sequencer to the code accumulator
  typedef struct packed {
    logic step;
    logic clear;
  } rsd_acc_ctrl_t;

  // status of the code accumulator for the current bit
  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   length;
  } rsd_acc_res_t;

endpackage

@@ design/rsd_in_if.sv @@
// rsd_in_if: input word channel of the rice stream decoder, valid/ready handshake
// depends on rsd_pkg

interface rsd_in_if
  import rsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_word;
  logic              restart;

  modport source (output valid, output data_word, output restart, input ready);
  modport sink   (input valid, input data_word, input restart, output ready);
endinterface

@@ design/rsd_out_if.sv @@
// rsd_out_if: decoded value channel of the rice stream decoder, valid/ready handshake
// depends on rsd_pkg

interface rsd_out_if
  import rsd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [LEN_W-1:0]   code_length;
  logic               last;

  modport source (output valid, output value, output code_length, output last, input ready);
  modport sink   (input valid, input value, input code_length, input last, output ready);
endinterface

@@ design/rsd_code_acc.sv @@
// rsd_code_acc: per-bit rice code state (unary count, remainder, length) and value shift
// depends on rsd_pkg

module rsd_code_acc
  import rsd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rsd_acc_ctrl_t ctrl_i,
  input  logic          bit_i,
  input  logic [K_W-1:0] k_i,
  output rsd_acc_res_t  res_o
);

  logic [QUOT_W-1:0] quot_q, quot_d;
  logic              in_rem_q, in_rem_d;
  logic [REM_W-1:0]  rem_acc_q, rem_acc_d;
  logic [K_W-1:0]    rem_seen_q, rem_seen_d;
  logic [LEN_W-1:0]  len_q, len_d;

  logic [LEN_W-1:0]  len_inc;
  logic [K_W-1:0]    seen_inc;
  logic [REM_W-1:0]  acc_or;
  logic              done;

  // saturating length count and remainder bit insertion
  assign len_inc  = (len_q == LEN_MAX) ? len_q : len_q + LEN_W'(1);
  assign seen_inc = rem_seen_q + K_W'(1);
  assign acc_or   = (rem_seen_q < K_W'(REM_W)) ?
                    (rem_acc_q | (REM_W'(bit_i) << rem_seen_q)) : rem_acc_q;

  // next code state for the current bit
  always_comb begin
    quot_d     = quot_q;
    in_rem_d   = in_rem_q;
    rem_acc_d  = rem_acc_q;
    rem_seen_d = rem_seen_q;
    len_d      = len_inc;
    done       = 1'b0;
    if (!in_rem_q) begin
      if (bit_i) begin
        quot_d = quot_q + QUOT_W'(1);
      end else begin
        in_rem_d   = 1'b1;
        rem_acc_d  = '0;
        rem_seen_d = '0;
      end
    end else begin
      rem_acc_d  = acc_or;
      rem_seen_d = seen_inc;
      if (seen_inc >= k_i) begin
        done       = 1'b1;
        quot_d     = '0;
        in_rem_d   = 1'b0;
        rem_acc_d  = '0;
        rem_seen_d = '0;
        len_d      = '0;
      end
    end
    if (ctrl_i.clear) begin
      quot_d     = '0;
      in_rem_d   = 1'b0;
      rem_acc_d  = '0;
      rem_seen_d = '0;
      len_d      = '0;
    end
  end

  // code state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q     <= '0;
      in_rem_q   <= 1'b0;
      rem_acc_q  <= '0;
      rem_seen_q <= '0;
      len_q      <= '0;
    end else if (ctrl_i.step || ctrl_i.clear) begin
      quot_q     <= quot_d;
      in_rem_q   <= in_rem_d;
      rem_acc_q  <= rem_acc_d;
      rem_seen_q <= rem_seen_d;
      len_q      <= len_d;
    end
  end

  // value shifter: quotient moved above the remainder
  assign res_o.done   = done;
  assign res_o.value  = (quot_q << k_i) | VALUE_W'(acc_or);
  assign res_o.length = len_inc;

endmodule

@@ design/rice_stream_decoder_unit.sv @@
// rice_stream_decoder_unit: top level of the streaming golomb-rice decoder
// depends on rsd_pkg, rsd_in_if, rsd_out_if and rsd_code_acc
//
//  channel   dir  transaction                      handshake
//  in_i      in   data_word[31:0], restart         valid / ready
//  out_o     out  value[31:0], code_length[31:0],  valid / ready
//                 last
//  cfg       in   cfg_wdata_i[4:0] (k)             cfg_we_i, no wait
//
//  a word is accepted in idle, walked through the word shift register in busy, one bit
//  a cycle while not stalled, and its last pending value is sent in flush. a code
//  completing while a finished value still waits stalls the bit walk for as long as
//  the output holds back. reset is asynchronous, active low: it clears the code state
//  and loads k with 6. in_i is ready only in idle.

module rice_stream_decoder_unit
  import rsd_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  rsd_in_if.sink         in_i,
  rsd_out_if.source      out_o,
  input  logic           cfg_we_i,
  input  logic [K_W-1:0] cfg_wdata_i
);

  rsd_state_e            state_q, state_d;
  logic [K_W-1:0]        k_q;
  logic [K_W-1:0]        k_eff;
  logic [DATA_W-1:0]     word_q, word_d;
  logic [BIT_IDX_W-1:0]  bit_idx_q, bit_idx_d;
  logic [COUNT_W-1:0]    count_q, count_d;

  logic                  pend_valid_q, pend_valid_d;
  logic [VALUE_W-1:0]    pend_value_q, pend_value_d;
  logic [LEN_W-1:0]      pend_len_q, pend_len_d;

  logic                  out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]    out_value_q, out_value_d;
  logic [LEN_W-1:0]      out_len_q, out_len_d;
  logic                  out_last_q, out_last_d;

  logic                  out_free;
  logic                  accept;
  logic                  keep;
  rsd_acc_ctrl_t         acc_ctrl;
  rsd_acc_res_t          acc_res;

  // configuration register, k of zero reads as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= K_RESET;
    end else if (cfg_we_i) begin
      k_q <= cfg_wdata_i;
    end
  end

  assign k_eff = (k_q == '0) ? K_W'(1) : k_q;

  // code accumulator
  rsd_code_acc u_code_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .bit_i  (word_q[0]),
    .k_i    (k_eff),
    .res_o  (acc_res)
  );

  assign out_free  = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;
  assign keep      = count_q < COUNT_W'(MAX_RESULTS);
  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer: bit walk, pending result and output register
  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    bit_idx_d    = bit_idx_q;
    count_d      = count_q;
    pend_valid_d = pend_valid_q;
    pend_value_d = pend_value_q;
    pend_len_d   = pend_len_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;
    acc_ctrl     = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          acc_ctrl.clear = in_i.restart;
          word_d         = in_i.data_word;
          bit_idx_d      = '0;
          count_d        = '0;
          state_d        = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (!(acc_res.done && keep && pend_valid_q && !out_free)) begin
          acc_ctrl.step = 1'b1;
          word_d        = word_q >> 1;
          bit_idx_d     = bit_idx_q + BIT_IDX_W'(1);
          if (acc_res.done && keep) begin
            count_d = count_q + COUNT_W'(1);
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_value_d = pend_value_q;
              out_len_d   = pend_len_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_value_d = acc_res.value;
            pend_len_d   = acc_res.length;
          end
          if (bit_idx_q == BIT_IDX_W'(WORD_BITS - 1)) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = pend_value_q;
          out_len_d    = pend_len_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bit_idx_q    <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_idx_q    <= bit_idx_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    pend_value_q <= pend_value_d;
    pend_len_q   <= pend_len_d;
    out_value_q  <= out_value_d;
    out_len_q    <= out_len_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value       = out_value_q;
  assign out_o.code_length = out_len_q;
  assign out_o.last        = out_last_q;

endmodule
